>>> rtl/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache.
package lkvc_pkg;

   // Field widths fixed by the item format
   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CAP_W = 5;

   // Operation codes
   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   // Capacity after reset, and the value returned by a get that misses
   localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
   localparam logic [VAL_W-1:0] MISS_VALUE = '1;

   // Request item
   typedef struct packed {
      logic                    opcode;
      logic signed [KEY_W-1:0] lookup_key;
      logic signed [VAL_W-1:0] write_value;
   } lkvc_req_type;

   // Result item
   typedef struct packed {
      logic                    hit;
      logic signed [VAL_W-1:0] read_value;
   } lkvc_rsp_type;

   // Update command broadcast to every entry
   typedef struct packed {
      logic update;         // promote the selected entry this cycle
      logic tgt_was_valid;  // selected entry held a live key before
      logic write_key;      // load key and set valid in the selected entry
      logic write_value;    // load value in the selected entry
   } lkvc_upd_type;

endpackage

>>> rtl/lkvc_entry.sv
// One cache entry: key, value, valid bit, recency rank and key compare.
module lkvc_entry #(
   parameter int RANK_W = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lkvc_pkg::lkvc_req_type item,
   input  lkvc_pkg::lkvc_upd_type upd,
   input  logic                   sel,
   input  logic [RANK_W-1:0]      tgt_rank,
   input  logic [RANK_W-1:0]      last_rank,
   output logic                   match,
   output logic                   victim,
   output logic                   valid,
   output logic [RANK_W-1:0]      rank,
   output logic [lkvc_pkg::VAL_W-1:0] value
);
   import lkvc_pkg::*;

   logic [KEY_W-1:0]  key_ff;
   logic [KEY_W-1:0]  key_in;
   logic [VAL_W-1:0]  value_ff;
   logic [VAL_W-1:0]  value_in;
   logic              valid_ff;
   logic              valid_in;
   logic [RANK_W-1:0] rank_ff;
   logic [RANK_W-1:0] rank_in;

   // Associative compare and least-recent flag
   assign match  = valid_ff && (key_ff == item.lookup_key);
   assign victim = valid_ff && (rank_ff == last_rank);
   assign valid  = valid_ff;
   assign rank   = rank_ff;
   assign value  = value_ff;

   // Payload and rank update
   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      valid_in = valid_ff;
      rank_in  = rank_ff;
      if (upd.update) begin
         if (sel) begin
            rank_in = '0;
            if (upd.write_key) begin
               key_in   = item.lookup_key;
               valid_in = 1'b1;
            end
            if (upd.write_value) begin
               value_in = item.write_value;
            end
         end else if (valid_ff && (!upd.tgt_was_valid || rank_ff < tgt_rank)) begin
            // entries ahead of the promoted one move back a place
            rank_in = rank_ff + RANK_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
      end
   end

endmodule

>>> rtl/lru_key_value_cache_core.sv
// LRU key-value cache core: input register, entry array, result register.
// A taken item passes the input register and then the result register, whose output strobes rsp_valid.
// Throughput: one item per cycle; busy stays low, the lookup, victim choice and
// rank update of one item all fit between the input and result registers.
// Reset clears all valid bits, ranks and occupancy and sets capacity to 16.
// The receiver cannot stall, so nothing holds results back.
module lru_key_value_cache_core #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  lkvc_pkg::lkvc_req_type         req_data,
   output logic                           rsp_valid,
   output lkvc_pkg::lkvc_rsp_type         rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lkvc_pkg::CAP_W-1:0]     csr_data
);
   import lkvc_pkg::*;

   localparam int RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int OCC_W  = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

   // Configuration and occupancy
   logic [CAP_W-1:0] cap_ff;
   logic [OCC_W-1:0] occ_ff;
   logic [OCC_W-1:0] occ_in;

   // Input register
   logic         item_vld_ff;
   lkvc_req_type item_ff;

   // Result register
   logic         rsp_vld_ff;
   lkvc_rsp_type rsp_ff;
   lkvc_rsp_type rsp_in;

   // Entry array signals
   logic [MAX_ENTRIES-1:0] match_vec;
   logic [MAX_ENTRIES-1:0] victim_vec;
   logic [MAX_ENTRIES-1:0] valid_vec;
   logic [MAX_ENTRIES-1:0] free_vec;
   logic [MAX_ENTRIES-1:0] first_free;
   logic [MAX_ENTRIES-1:0] sel_vec;
   logic [RANK_W-1:0]      rank_arr  [MAX_ENTRIES];
   logic [VAL_W-1:0]       value_arr [MAX_ENTRIES];
   logic [RANK_W-1:0]      tgt_rank;
   logic [RANK_W-1:0]      last_rank;
   logic [VAL_W-1:0]       hit_value;
   logic [CMP_W-1:0]       cap_ext;
   logic [CMP_W-1:0]       eff_cap;
   logic                   hit;
   logic                   full;
   lkvc_upd_type           upd;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // Capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         cap_ff <= csr_data;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
      end else begin
         item_vld_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         item_ff <= req_data;
      end
   end

   // Entry array
   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_entry
      lkvc_entry #(
         .RANK_W (RANK_W)
      ) u_entry (
         .clock     (clock),
         .reset     (reset),
         .item      (item_ff),
         .upd       (upd),
         .sel       (sel_vec[g]),
         .tgt_rank  (tgt_rank),
         .last_rank (last_rank),
         .match     (match_vec[g]),
         .victim    (victim_vec[g]),
         .valid     (valid_vec[g]),
         .rank      (rank_arr[g]),
         .value     (value_arr[g])
      );
   end

   // Effective capacity: zero reads as one, saturated at the entry count
   assign cap_ext = CMP_W'(cap_ff);
   always_comb begin
      eff_cap = cap_ext;
      if (cap_ext == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
         eff_cap = CMP_W'(MAX_ENTRIES);
      end
   end

   assign full      = CMP_W'(occ_ff) >= eff_cap;
   assign last_rank = RANK_W'(occ_ff - OCC_W'(1));
   assign hit       = |match_vec;

   // Lowest free slot as a one-hot vector
   assign free_vec   = ~valid_vec;
   assign first_free = free_vec & (~free_vec + MAX_ENTRIES'(1));

   // Pick the entry to promote and the command for the array
   always_comb begin
      sel_vec = '0;
      upd     = '0;
      if (item_vld_ff) begin
         if (hit) begin
            sel_vec         = match_vec;
            upd.update      = 1'b1;
            upd.write_value = (item_ff.opcode == OP_PUT);
         end else if (item_ff.opcode == OP_PUT) begin
            sel_vec         = full ? victim_vec : first_free;
            upd.update      = 1'b1;
            upd.write_key   = 1'b1;
            upd.write_value = 1'b1;
         end
      end
      upd.tgt_was_valid = |(sel_vec & valid_vec);
   end

   // Rank and value of the selected or matching entry (one-hot OR select)
   always_comb begin
      tgt_rank  = '0;
      hit_value = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         tgt_rank  = tgt_rank  | (sel_vec[i]   ? rank_arr[i]  : '0);
         hit_value = hit_value | (match_vec[i] ? value_arr[i] : '0);
      end
   end

   // Occupancy grows only when a new key lands in a free slot
   always_comb begin
      occ_in = occ_ff;
      if (item_vld_ff && !hit && item_ff.opcode == OP_PUT && !full) begin
         occ_in = occ_ff + OCC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   // Result item
   always_comb begin
      rsp_in.hit = hit;
      if (item_ff.opcode == OP_PUT) begin
         rsp_in.read_value = '0;
      end else if (hit) begin
         rsp_in.read_value = hit_value;
      end else begin
         rsp_in.read_value = MISS_VALUE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= item_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (item_vld_ff) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
